[rtl/cre_pkg.sv]
package cre_pkg;

    // Width of the kernel selection register.
    localparam int KERNEL_MODE_W = 3;

    // Kernel selection codes. The codes five to seven select no kernel and give a zero result.
    typedef enum logic [KERNEL_MODE_W-1:0] {
        KM_C0 = 3'd0,
        KM_C2 = 3'd1,
        KM_C4 = 3'd2,
        KM_C6 = 3'd3,
        KM_TP = 3'd4
    } t_kernel_mode;

    // Control that travels with an item from stage to stage.
    typedef struct packed {
        logic valid;
        logic in_support;
    } t_stage_ctl;

endpackage

[rtl/cre_power_pipe.sv]
module cre_power_pipe
    import cre_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [FRAC_BITS:0]     i_psi,
    output t_stage_ctl             o_ctl,
    output logic [FRAC_BITS-1:0]   o_psi,
    output logic [FRAC_BITS:0]     o_d,
    output logic [FRAC_BITS:0]     o_d2,
    output logic [FRAC_BITS:0]     o_d4,
    output logic [FRAC_BITS-1:0]   o_s2,
    output logic [FRAC_BITS-1:0]   o_s3,
    output logic [FRAC_BITS+3:0]   o_ks2
);

    localparam int F  = FRAC_BITS;
    localparam int W  = FRAC_BITS + 1;
    localparam int KW = FRAC_BITS + 4;
    localparam logic [W-1:0]  ONE    = {1'b1, {F{1'b0}}};
    localparam logic [F-1:0]  HALF   = {1'b1, {(F-1){1'b0}}};
    localparam logic [KW-1:0] K_35_3 = KW'(((64'd70 << F) + 64'd3) / 64'd6);

    localparam int PDW = 2 * W;
    localparam int PSW = 2 * F + 1;
    localparam int PKW = KW + F + 1;

    // Stage 1: distance from the support edge.
    t_stage_ctl       r_s1_ctl;
    logic [F-1:0]     r_s1_psi;
    logic [W-1:0]     r_s1_d;

    // Stage 2: squares.
    t_stage_ctl       r_s2_ctl;
    logic [F-1:0]     r_s2_psi;
    logic [W-1:0]     r_s2_d;
    logic [W-1:0]     r_s2_d2;
    logic [F-1:0]     r_s2_s2;

    // Stage 3: fourth power, cube and scaled square.
    t_stage_ctl       r_s3_ctl;
    logic [F-1:0]     r_s3_psi;
    logic [W-1:0]     r_s3_d;
    logic [W-1:0]     r_s3_d2;
    logic [W-1:0]     r_s3_d4;
    logic [F-1:0]     r_s3_s2;
    logic [F-1:0]     r_s3_s3;
    logic [KW-1:0]    r_s3_ks2;

    logic [PDW-1:0]   p_dd;
    logic [PSW-1:0]   p_ss;
    logic [PDW-1:0]   p_d4;
    logic [PSW-1:0]   p_s3;
    logic [PKW-1:0]   p_ks;

    assign p_dd = PDW'(r_s1_d) * PDW'(r_s1_d) + PDW'(HALF);
    assign p_ss = PSW'(r_s1_psi) * PSW'(r_s1_psi) + PSW'(HALF);
    assign p_d4 = PDW'(r_s2_d2) * PDW'(r_s2_d2) + PDW'(HALF);
    assign p_s3 = PSW'(r_s2_s2) * PSW'(r_s2_psi) + PSW'(HALF);
    assign p_ks = PKW'(K_35_3) * PKW'(r_s2_s2) + PKW'(HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_s3_ctl <= '0;
        end else if (i_en) begin
            r_s1_ctl.valid      <= i_valid;
            r_s1_ctl.in_support <= ~i_psi[F];
            r_s2_ctl            <= r_s1_ctl;
            r_s3_ctl            <= r_s2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_psi <= i_psi[F-1:0];
            r_s1_d   <= ONE - W'(i_psi[F-1:0]);

            r_s2_psi <= r_s1_psi;
            r_s2_d   <= r_s1_d;
            r_s2_d2  <= p_dd[F +: W];
            r_s2_s2  <= p_ss[F +: F];

            r_s3_psi <= r_s2_psi;
            r_s3_d   <= r_s2_d;
            r_s3_d2  <= r_s2_d2;
            r_s3_d4  <= p_d4[F +: W];
            r_s3_s2  <= r_s2_s2;
            r_s3_s3  <= p_s3[F +: F];
            r_s3_ks2 <= p_ks[F +: KW];
        end
    end

    assign o_ctl = r_s3_ctl;
    assign o_psi = r_s3_psi;
    assign o_d   = r_s3_d;
    assign o_d2  = r_s3_d2;
    assign o_d4  = r_s3_d4;
    assign o_s2  = r_s3_s2;
    assign o_s3  = r_s3_s3;
    assign o_ks2 = r_s3_ks2;

endmodule

[rtl/cre_blend_pipe.sv]
module cre_blend_pipe
    import cre_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [KERNEL_MODE_W-1:0]   i_kernel_mode,
    input  t_stage_ctl                 i_ctl,
    input  logic [FRAC_BITS-1:0]       i_psi,
    input  logic [FRAC_BITS:0]         i_d,
    input  logic [FRAC_BITS:0]         i_d2,
    input  logic [FRAC_BITS:0]         i_d4,
    input  logic [FRAC_BITS-1:0]       i_s2,
    input  logic [FRAC_BITS-1:0]       i_s3,
    input  logic [FRAC_BITS+3:0]       i_ks2,
    output logic                       o_valid,
    output logic [FRAC_BITS:0]         o_value
);

    localparam int F   = FRAC_BITS;
    localparam int W   = FRAC_BITS + 1;
    localparam int PW  = FRAC_BITS + 7;
    localparam int PDW = 2 * W;
    localparam int PFW = W + PW;
    localparam int RW  = PFW - F;
    localparam logic [W-1:0] ONE  = {1'b1, {F{1'b0}}};
    localparam logic [F-1:0] HALF = {1'b1, {(F-1){1'b0}}};

    // Stage 4: the power of the distance term and the polynomial factor.
    logic             r_s4_valid;
    logic             r_s4_zero;
    logic [W-1:0]     r_s4_a;
    logic [PW-1:0]    r_s4_b;

    // Stage 5: final rounded product, also the output register.
    logic             r_s5_valid;
    logic [W-1:0]     r_s5_value;

    logic [PDW-1:0]   p_d6;
    logic [PDW-1:0]   p_d8;
    logic [W-1:0]     n_a;
    logic [PW-1:0]    n_b;
    logic             n_bad_mode;
    logic [PFW-1:0]   p_fin;
    logic [RW-1:0]    rnd;
    logic [W-1:0]     n_value;

    assign p_d6 = PDW'(i_d4) * PDW'(i_d2) + PDW'(HALF);
    assign p_d8 = PDW'(i_d4) * PDW'(i_d4) + PDW'(HALF);

    // Every kernel ends in one rounded product. The plain square multiplies by one, which the
    // rounding leaves exact, and the fifth power multiplies the fourth power by the distance.
    always_comb begin
        n_a        = i_d2;
        n_b        = PW'(ONE);
        n_bad_mode = 1'b0;
        case (i_kernel_mode)
            KM_C0: begin
                n_a = i_d2;
                n_b = PW'(ONE);
            end
            KM_C2: begin
                n_a = i_d4;
                n_b = PW'(i_psi) * PW'(4) + PW'(ONE);
            end
            KM_C4: begin
                n_a = p_d6[F +: W];
                n_b = PW'(i_ks2) + PW'(i_psi) * PW'(6) + PW'(ONE);
            end
            KM_C6: begin
                n_a = p_d8[F +: W];
                n_b = PW'(i_s3) * PW'(32) + PW'(i_s2) * PW'(25)
                    + PW'(i_psi) * PW'(8) + PW'(ONE);
            end
            KM_TP: begin
                n_a = i_d4;
                n_b = PW'(i_d);
            end
            default: begin
                n_bad_mode = 1'b1;
            end
        endcase
    end

    assign p_fin = PFW'(r_s4_a) * PFW'(r_s4_b) + PFW'(HALF);
    assign rnd   = p_fin[F +: RW];

    always_comb begin
        if (r_s4_zero) begin
            n_value = '0;
        end else if (rnd > RW'(ONE)) begin
            n_value = ONE;
        end else begin
            n_value = rnd[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else if (i_en) begin
            r_s4_valid <= i_ctl.valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_zero  <= ~i_ctl.in_support | n_bad_mode;
            r_s4_a     <= n_a;
            r_s4_b     <= n_b;
            r_s5_value <= n_value;
        end
    end

    assign o_valid = r_s5_valid;
    assign o_value = r_s5_value;

endmodule

[rtl/compact_rbf_evaluator_unit.sv]
// Compact-support radial basis evaluator (Wendland C0, C2, C4, C6 and truncated fifth power).
// Input channel: i_psi_valid / o_psi_ready carry one distance item i_psi in unsigned fixed
// point with FRAC_BITS fraction bits; a distance of one or more lies outside the support and
// gives a zero value. Output channel: o_value_valid / i_value_ready carry the basis value
// o_value in the same format, rounded to nearest and saturated at one.
// The kernel is chosen by writing i_cfg_wdata with i_cfg_we high; the write takes effect at
// once and is only to be made while no item is in flight, which the block does not enforce.
// Codes five to seven yield zero values. The datapath is five register stages long:
// distance, squares, fourth power and cube, kernel power and polynomial, final product. An
// item accepted into the first stage passes through them in order to o_value. One item is
// taken every cycle as long as the receiver keeps i_value_ready high, so the throughput is
// one item per cycle; the multiplier stages set the depth, each holding its rounded products.
// When the receiver stalls with a result waiting, the whole pipeline holds, o_psi_ready drops
// and nothing is lost or repeated; an empty last stage never holds the pipeline.
// Reset is synchronous and active low. It empties the pipeline and selects the C0 kernel.
module compact_rbf_evaluator_unit
    import cre_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [KERNEL_MODE_W-1:0]   i_cfg_wdata,
    input  logic                       i_psi_valid,
    output logic                       o_psi_ready,
    input  logic [FRAC_BITS:0]         i_psi,
    output logic                       o_value_valid,
    input  logic                       i_value_ready,
    output logic [FRAC_BITS:0]         o_value
);

    logic [KERNEL_MODE_W-1:0]   r_kernel_mode;
    logic                       pipe_en;
    t_stage_ctl                 front_ctl;
    logic [FRAC_BITS-1:0]       front_psi;
    logic [FRAC_BITS:0]         front_d;
    logic [FRAC_BITS:0]         front_d2;
    logic [FRAC_BITS:0]         front_d4;
    logic [FRAC_BITS-1:0]       front_s2;
    logic [FRAC_BITS-1:0]       front_s3;
    logic [FRAC_BITS+3:0]       front_ks2;

    // The pipeline advances whenever the output register is empty or is being drained.
    assign pipe_en     = ~o_value_valid | i_value_ready;
    assign o_psi_ready = pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_mode <= KM_C0;
        end else if (i_cfg_we) begin
            r_kernel_mode <= i_cfg_wdata;
        end
    end

    cre_power_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_power (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_psi_valid),
        .i_psi   (i_psi),
        .o_ctl   (front_ctl),
        .o_psi   (front_psi),
        .o_d     (front_d),
        .o_d2    (front_d2),
        .o_d4    (front_d4),
        .o_s2    (front_s2),
        .o_s3    (front_s3),
        .o_ks2   (front_ks2)
    );

    cre_blend_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (pipe_en),
        .i_kernel_mode (r_kernel_mode),
        .i_ctl         (front_ctl),
        .i_psi         (front_psi),
        .i_d           (front_d),
        .i_d2          (front_d2),
        .i_d4          (front_d4),
        .i_s2          (front_s2),
        .i_s3          (front_s3),
        .i_ks2         (front_ks2),
        .o_valid       (o_value_valid),
        .o_value       (o_value)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import cre_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int PIPE_DEPTH = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 84;
    localparam int REPORT_LINES = 40;

    // Fixed-point constants of the kernels: one, half an LSB for rounding, and 35/3.
    localparam longint unsigned FX_ONE = 64'd1 << FRAC_BITS;
    localparam longint unsigned FX_HALF = FX_ONE >> 1;
    localparam longint unsigned FX_K35_3 = ((64'd70 << FRAC_BITS) + 64'd3) / 64'd6;

    // Kernel codes that the package leaves unnamed; they must give zero values.
    localparam logic [KERNEL_MODE_W-1:0] MODE_UNUSED_5 = 3'd5;
    localparam logic [KERNEL_MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [KERNEL_MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

    // One expected value, with the distance and kernel that produced it for reporting.
    typedef struct {
        logic [FRAC_BITS:0]     psi;
        logic [KERNEL_MODE_W-1:0] mode;
        logic [FRAC_BITS:0]     value;
    } t_rbf_expect;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [KERNEL_MODE_W-1:0] i_cfg_wdata = '0;
    logic                     i_psi_valid = 1'b0;
    logic                     o_psi_ready;
    logic [FRAC_BITS:0]       i_psi = '0;
    logic                     o_value_valid;
    logic                     i_value_ready = 1'b0;
    logic [FRAC_BITS:0]       o_value;

    // Distances waiting to be sent, and values expected back, oldest first.
    logic [FRAC_BITS:0] pending_psi[$];
    t_rbf_expect        expected_values[$];

    // Our copy of the kernel selection register.
    logic [KERNEL_MODE_W-1:0] kernel_sel = KM_C0;

    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned items_accepted = 0;
    int unsigned values_checked = 0;
    int unsigned outside_count = 0;
    int unsigned clamp_count = 0;
    int unsigned mode_writes = 0;

    logic [KERNEL_MODE_W-1:0] phase_modes[RANDOM_PHASES] = '{
        KM_TP, KM_C4, MODE_UNUSED_5, KM_C0, KM_C2, KM_C6,
        MODE_UNUSED_6, KM_C4, KM_TP, KM_C6, KM_C2, KM_C0
    };

    compact_rbf_evaluator_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_psi_valid   (i_psi_valid),
        .o_psi_ready   (o_psi_ready),
        .i_psi         (i_psi),
        .o_value_valid (o_value_valid),
        .i_value_ready (i_value_ready),
        .o_value       (o_value)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Fixed-point product, rounded half up at FRAC_BITS fraction bits.
    function automatic longint unsigned fx_product(longint unsigned a, longint unsigned b);
        return (a * b + FX_HALF) >> FRAC_BITS;
    endfunction

    // Basis value of one distance under the given kernel. Every product is rounded
    // on its own, in the same order as the hardware chain, and the result is clamped
    // at one because rounding near zero distance can push it just above.
    function automatic logic [FRAC_BITS:0] rbf_kernel_value(logic [FRAC_BITS:0] psi,
                                                            logic [KERNEL_MODE_W-1:0] sel);
        longint unsigned s;
        longint unsigned d;
        longint unsigned d2;
        longint unsigned d4;
        longint unsigned s2;
        longint unsigned s3;
        longint unsigned r;
        s = 64'(psi);
        r = 0;
        if (s < FX_ONE) begin
            d  = FX_ONE - s;
            d2 = fx_product(d, d);
            d4 = fx_product(d2, d2);
            s2 = fx_product(s, s);
            s3 = fx_product(s2, s);
            case (sel)
                KM_C0: r = d2;
                KM_C2: r = fx_product(d4, 4 * s + FX_ONE);
                KM_C4: r = fx_product(fx_product(d4, d2),
                                      fx_product(FX_K35_3, s2) + 6 * s + FX_ONE);
                KM_C6: r = fx_product(fx_product(d4, d4),
                                      32 * s3 + 25 * s2 + 8 * s + FX_ONE);
                KM_TP: r = fx_product(d4, d);
                default: r = 0;
            endcase
            if (r > FX_ONE) begin
                r = FX_ONE;
            end
        end
        return r[FRAC_BITS:0];
    endfunction

    // Idle cycles before the next item on one side. The side switches now and then
    // between a calm stretch with no idling and a stretch of random gaps.
    function automatic int unsigned draw_idle(inout bit calm);
        if ($urandom_range(0, 15) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    // Most distances fall inside the support, where the kernels do their work. Some
    // crowd both ends of the support, and some cover the whole field so that the
    // top bit and every other bit take both values.
    function automatic logic [FRAC_BITS:0] draw_psi();
        case ($urandom_range(0, 9))
            0, 1: return (FRAC_BITS + 1)'($urandom_range(0, (1 << (FRAC_BITS + 1)) - 1));
            2: begin
                if ($urandom_range(0, 1) == 0) begin
                    return (FRAC_BITS + 1)'($urandom_range(0, 15));
                end
                return (FRAC_BITS + 1)'($urandom_range(FX_ONE - 16, FX_ONE + 16));
            end
            default: return (FRAC_BITS + 1)'($urandom_range(0, FX_ONE - 1));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= REPORT_LINES) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // The kernel register is written only with nothing in flight, so our copy may be
    // updated at once: no item is accepted under the old setting after this point.
    task automatic write_kernel_mode(input logic [KERNEL_MODE_W-1:0] mode);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        kernel_sel = mode;
        mode_writes++;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Waits until every queued distance has been sent and every value has come back.
    // The check runs on the falling edge, where both always blocks have settled.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_psi.size() != 0 || i_psi_valid || expected_values.size() != 0);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    // Sender. An accepted item gets its expected value at the edge where it is taken;
    // after that the next distance goes out once its drawn gap has run down.
    always @(posedge i_clk) begin : psi_driver
        logic        next_valid;
        t_rbf_expect entry;
        if (!i_rst_n) begin
            i_psi_valid <= 1'b0;
        end else begin
            next_valid = i_psi_valid;
            if (i_psi_valid && o_psi_ready) begin
                entry.psi   = i_psi;
                entry.mode  = kernel_sel;
                entry.value = rbf_kernel_value(i_psi, kernel_sel);
                expected_values.push_back(entry);
                items_accepted++;
                if (i_psi >= FX_ONE) begin
                    outside_count++;
                end
                if (entry.value == FX_ONE && i_psi != 0) begin
                    clamp_count++;
                end
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_psi.size() != 0) begin
                    i_psi <= pending_psi.pop_front();
                    next_valid = 1'b1;
                    send_wait = draw_idle(send_calm);
                end
            end
            i_psi_valid <= next_valid;
        end
    end

    // Receiver. Each value taken is compared with the oldest expectation; then, unless the
    // freshly drawn gap is zero, ready drops until that gap has run down.
    always @(posedge i_clk) begin : value_monitor
        logic        next_ready;
        t_rbf_expect entry;
        if (!i_rst_n) begin
            i_value_ready <= 1'b0;
        end else begin
            next_ready = i_value_ready;
            if (o_value_valid && i_value_ready) begin
                if (expected_values.size() == 0) begin
                    report_mismatch($sformatf("value %h arrived with nothing expected",
                                              o_value));
                end else begin
                    entry = expected_values.pop_front();
                    values_checked++;
                    if (o_value !== entry.value) begin
                        report_mismatch($sformatf("psi %h mode %0d: value %h, expected %h",
                                                  entry.psi, entry.mode, o_value,
                                                  entry.value));
                    end
                end
                recv_wait = draw_idle(recv_calm);
                next_ready = (recv_wait == 0);
            end else if (!i_value_ready) begin
                if (recv_wait > 0) begin
                    recv_wait--;
                end
                next_ready = (recv_wait == 0);
            end
            i_value_ready <= next_ready;
        end
    end

    // Watchdog over the whole run, including the drain at the end.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d values still expected",
                     cycle_count, expected_values.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first under the reset kernel C0 without any write: zero
        // distance, the smallest step, the middle, the last point inside the support,
        // exactly one, just past one, the top of the field and two patterned values.
        pending_psi.push_back(17'h00000);
        pending_psi.push_back(17'h00001);
        pending_psi.push_back(17'h08000);
        pending_psi.push_back(17'h0FFFF);
        pending_psi.push_back(17'h10000);
        pending_psi.push_back(17'h10001);
        pending_psi.push_back(17'h1FFFF);
        pending_psi.push_back(17'h0AAAA);
        pending_psi.push_back(17'h15555);
        wait_drained();

        // C6 has the longest polynomial; tiny distances round close to or above one.
        write_kernel_mode(KM_C6);
        pending_psi.push_back(17'h00000);
        pending_psi.push_back(17'h00001);
        pending_psi.push_back(17'h00002);
        pending_psi.push_back(17'h00100);
        pending_psi.push_back(17'h0FFFF);
        pending_psi.push_back(17'h10000);
        wait_drained();

        write_kernel_mode(KM_C2);
        pending_psi.push_back(17'h00001);
        pending_psi.push_back(17'h00040);
        pending_psi.push_back(17'h0FFFF);
        wait_drained();

        // The top code selects no kernel, so even zero distance must give zero.
        write_kernel_mode(MODE_UNUSED_7);
        pending_psi.push_back(17'h00000);
        pending_psi.push_back(17'h01000);
        wait_drained();

        // Random part: every named kernel and the unused codes five and six, each for a batch
        // of distances, with the register rewritten between batches.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_kernel_mode(phase_modes[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pending_psi.push_back(draw_psi());
            end
            wait_drained();
        end

        if (expected_values.size() != 0) begin
            report_mismatch($sformatf("%0d expected values never arrived",
                                      expected_values.size()));
        end

        $display("Covered %0d distances under %0d kernel settings, %0d of them outside",
                 items_accepted, mode_writes + 1, outside_count);
        $display("the support and %0d clamped at one; %0d values compared, %0d mismatches.",
                 clamp_count, values_checked, error_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/cre_pkg.sv
rtl/cre_power_pipe.sv
rtl/cre_blend_pipe.sv
rtl/compact_rbf_evaluator_unit.sv
tb/testbench.sv
